// File: hdl/sbb_pkg.sv
// Shared types, constants and codes for the separable box blur unit.
package sbb_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_MAX_RADIUS = 127;

    localparam int SAMPLE_W = 16;
    localparam int DIM_W    = 8;
    localparam int RAD_W    = 7;
    localparam int SUM_W    = 24;
    localparam int CNT_W    = 8;
    localparam int PIX_W    = 3 * SAMPLE_W;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_BLUR  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic             host_wr;
        logic             host_rd;
        logic             vert;
        logic [DIM_W-1:0] pos;
        logic [DIM_W-1:0] line;
        logic             addr_ld;
        logic             acc_clr;
        logic             acc_add;
        logic             acc_sub;
        logic             div_start;
        logic             dst_wr;
        logic             out_ld;
        logic             out_data;
        logic             out_status;
    } sbb_cmd_t;

    typedef struct packed {
        logic in_frame;
        logic div_busy;
    } sbb_sts_t;

endpackage

// File: hdl/separable_box_blur_unit.sv
// Top level: configuration registers, size clamping, controller and datapath.
//
// Separable box blur over an RGB frame of unsigned Q4.12 samples.
// Input channel (in_valid/in_ready) carries opcode, pixel_index and the three
// samples; output channel (out_valid/out_ready) returns one result per item:
// the samples of a read, zeros otherwise, and status 1 for a write or read
// index outside the frame in use. Registers blur_radius, image_width and
// image_height sit on the APB port at byte addresses 0, 4 and 8; write them
// only while idle. A write item is answered directly, a read item once the
// store's registered read port has delivered. A blur runs a row pass then a
// column pass, each line primed by fetching its first window samples, then
// for each output pixel a division by the bit-serial divider, which sets the
// pace, and a fetch of each sample leaving or entering the window.
// One item is processed at a time; the next is taken once the result
// register is free or being transferred. If the receiver stalls, the result
// holds and no new item is taken. Reset clears the control state and sets
// radius 1 and a 128 by 128 frame; store contents stay undefined until written.
module separable_box_blur_unit
    import sbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [13:0] pixel_index,
    input  logic [15:0] red_in,
    input  logic [15:0] green_in,
    input  logic [15:0] blue_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] red_out,
    output logic [15:0] green_out,
    output logic [15:0] blue_out,
    output logic        status
);

    logic [RAD_W-1:0] radius_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [RAD_W-1:0] eff_r;
    logic             cfg_wr;
    sbb_cmd_t         cmd;
    sbb_sts_t         sts;

    // Configuration writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_W'(1);
            width_reg  <= DIM_W'(128);
            height_reg <= DIM_W'(128);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_RADIUS: radius_reg <= pwdata[RAD_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_RADIUS: prdata = 32'(radius_reg);
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // Clamp sizes and radius to the supported range
    always_comb
    begin
        if (width_reg == '0)
            eff_w = DIM_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = DIM_W'(MAX_WIDTH);
        else
            eff_w = width_reg;

        if (height_reg == '0)
            eff_h = DIM_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            eff_h = DIM_W'(MAX_HEIGHT);
        else
            eff_h = height_reg;

        if (32'(radius_reg) > MAX_RADIUS)
            eff_r = RAD_W'(MAX_RADIUS);
        else
            eff_r = radius_reg;
    end

    sbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .eff_r     (eff_r),
        .cmd       (cmd),
        .sts       (sts)
    );

    sbb_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .eff_w       (eff_w),
        .eff_h       (eff_h),
        .pixel_index (pixel_index),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .status      (status)
    );

endmodule

// File: hdl/sbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbb_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sbb_div.sv
// Three-lane restoring divider, one quotient bit per cycle.
module sbb_div
    import sbb_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [2:0][SUM_W-1:0]         dividend,
    input  logic [CNT_W-1:0]              divisor,
    output logic                          busy,
    output logic [2:0][SAMPLE_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic                     busy_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [2:0][SUM_W-1:0]    quo_reg;
    logic [2:0][CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]         div_reg;
    logic [2:0][SUM_W-1:0]    quo_next;
    logic [2:0][CNT_W-1:0]    rem_next;
    logic [2:0][CNT_W:0]      shifted;

    // Shift in one dividend bit and subtract where it fits
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            shifted[c] = {rem_reg[c], quo_reg[c][SUM_W-1]};
            if (shifted[c] >= {1'b0, div_reg})
            begin
                rem_next[c] = CNT_W'(shifted[c] - {1'b0, div_reg});
                quo_next[c] = {quo_reg[c][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[c] = shifted[c][CNT_W-1:0];
                quo_next[c] = {quo_reg[c][SUM_W-2:0], 1'b0};
            end
        end
    end

    // Control: busy from start until every dividend bit has been shifted in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath of the three lanes
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            quotient[c] = quo_reg[c][SAMPLE_W-1:0];
        end
    end

endmodule

// File: hdl/sbb_dp.sv
// Datapath: frame and row-pass stores, window accumulator, divider, result register.
module sbb_dp
    import sbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sbb_cmd_t            cmd,
    output sbb_sts_t            sts,
    input  logic [DIM_W-1:0]    eff_w,
    input  logic [DIM_W-1:0]    eff_h,
    input  logic [13:0]         pixel_index,
    input  logic [15:0]         red_in,
    input  logic [15:0]         green_in,
    input  logic [15:0]         blue_in,
    output logic [15:0]         red_out,
    output logic [15:0]         green_out,
    output logic [15:0]         blue_out,
    output logic                status
);

    localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = $clog2(NPIX);

    logic [AW-1:0]               addr_reg;
    logic [2:0][SUM_W-1:0]       sum_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [PIX_W-1:0]            out_reg;
    logic                        status_reg;

    logic [DIM_W-1:0]            mul_a;
    logic [DIM_W-1:0]            add_b;
    logic [2*DIM_W-1:0]          prod;
    logic [2*DIM_W:0]            addr_sum;
    logic [2*DIM_W-1:0]          frame_size;

    logic [PIX_W-1:0]            frame_rdata;
    logic [PIX_W-1:0]            row_rdata;
    logic [PIX_W-1:0]            src_rdata;
    logic [PIX_W-1:0]            dst_wdata;
    logic [AW-1:0]               host_addr;
    logic                        frame_we;
    logic [AW-1:0]               frame_waddr;
    logic [PIX_W-1:0]            frame_wdata;
    logic [AW-1:0]               frame_raddr;

    logic [2:0][SUM_W-1:0]       dividend;
    logic                        div_busy;
    logic [2:0][SAMPLE_W-1:0]    quotient;

    // Check the host index against the frame in use
    assign frame_size = eff_w * eff_h;
    assign host_addr  = AW'(pixel_index);
    assign sts.in_frame = ({2'b0, pixel_index} < frame_size) && (32'(pixel_index) < NPIX);
    assign sts.div_busy = div_busy;

    // Raster address: row pass walks a row, column pass walks a column
    assign mul_a    = cmd.vert ? cmd.pos : cmd.line;
    assign add_b    = cmd.vert ? cmd.line : cmd.pos;
    assign prod     = mul_a * eff_w;
    assign addr_sum = {1'b0, prod} + {{(DIM_W + 1){1'b0}}, add_b};

    always_ff @(posedge clk)
    begin
        if (cmd.addr_ld)
        begin
            addr_reg <= AW'(addr_sum);
        end
    end

    // Stores
    assign src_rdata   = cmd.vert ? row_rdata : frame_rdata;
    assign dst_wdata   = {quotient[0], quotient[1], quotient[2]};
    assign frame_we    = (cmd.host_wr) || (cmd.dst_wr && cmd.vert);
    assign frame_waddr = cmd.host_wr ? host_addr : addr_reg;
    assign frame_wdata = cmd.host_wr ? {red_in, green_in, blue_in} : dst_wdata;
    assign frame_raddr = cmd.host_rd ? host_addr : addr_reg;

    sbb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (NPIX)
    ) u_frame (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    sbb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (NPIX)
    ) u_row (
        .clk   (clk),
        .we    (cmd.dst_wr && !cmd.vert),
        .waddr (addr_reg),
        .wdata (dst_wdata),
        .raddr (addr_reg),
        .rdata (row_rdata)
    );

    // Window accumulator: clear, add the entering sample, drop the leaving one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.acc_clr)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= sum_reg[c]
                    + SUM_W'(src_rdata[PIX_W-1-c*SAMPLE_W -: SAMPLE_W]);
            end
            count_reg <= count_reg + 1'b1;
        end
        else if (cmd.acc_sub)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= sum_reg[c]
                    - SUM_W'(src_rdata[PIX_W-1-c*SAMPLE_W -: SAMPLE_W]);
            end
            count_reg <= count_reg - 1'b1;
        end
    end

    // Round to nearest: add half the count before dividing
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            dividend[c] = sum_reg[c] + SUM_W'(count_reg >> 1);
        end
    end

    sbb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_reg    <= cmd.out_data ? frame_rdata : '0;
            status_reg <= cmd.out_status;
        end
    end

    assign red_out   = out_reg[PIX_W-1 -: SAMPLE_W];
    assign green_out = out_reg[PIX_W-1-SAMPLE_W -: SAMPLE_W];
    assign blue_out  = out_reg[SAMPLE_W-1:0];
    assign status    = status_reg;

endmodule

// File: hdl/sbb_ctrl.sv
// Controller: item handshake and the sequencer of the two blur passes.
module sbb_ctrl
    import sbb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    output logic               out_valid,
    input  logic               out_ready,
    input  logic [DIM_W-1:0]   eff_w,
    input  logic [DIM_W-1:0]   eff_h,
    input  logic [RAD_W-1:0]   eff_r,
    output sbb_cmd_t           cmd,
    input  sbb_sts_t           sts
);

    typedef enum logic [10:0] {
        ST_IDLE       = 11'b000_0000_0001,
        ST_RD_WAIT    = 11'b000_0000_0010,
        ST_LINE_START = 11'b000_0000_0100,
        ST_FETCH_ADDR = 11'b000_0000_1000,
        ST_FETCH_RD   = 11'b000_0001_0000,
        ST_FETCH_ACC  = 11'b000_0010_0000,
        ST_OUT_ADDR   = 11'b000_0100_0000,
        ST_DIV_RUN    = 11'b000_1000_0000,
        ST_DST_WR     = 11'b001_0000_0000,
        ST_NEXT       = 11'b010_0000_0000,
        ST_FINISH     = 11'b100_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        KIND_PRIME = 2'd0,
        KIND_SUB   = 2'd1,
        KIND_ADD   = 2'd2
    } kind_t;

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic              vert_reg, vert_next;
    logic [DIM_W-1:0]  line_reg, line_next;
    logic [DIM_W-1:0]  i_reg, i_next;
    logic [DIM_W-1:0]  fpos_reg, fpos_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              out_valid_reg, out_valid_next;

    logic [DIM_W-1:0]  n_len;
    logic [DIM_W-1:0]  n_lines;
    logic [DIM_W-1:0]  r_ext;
    logic [DIM_W-1:0]  last;
    logic [DIM_W:0]    add_pos;
    logic              add_ok;
    logic              accept;

    // Line geometry of the current pass
    assign n_len   = vert_reg ? eff_h : eff_w;
    assign n_lines = vert_reg ? eff_w : eff_h;
    assign r_ext   = DIM_W'(eff_r);
    assign last    = (r_ext < n_len) ? r_ext : n_len - 1'b1;
    assign add_pos = {1'b0, i_reg} + {1'b0, r_ext} + 1'b1;
    assign add_ok  = add_pos < {1'b0, n_len};

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        vert_next  = vert_reg;
        line_next  = line_reg;
        i_next     = i_reg;
        fpos_next  = fpos_reg;
        rd_ok_next = rd_ok_reg;

        cmd            = '0;
        cmd.vert       = vert_reg;
        cmd.pos        = fpos_reg;
        cmd.line       = line_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_WRITE:
                        begin
                            cmd.host_wr    = sts.in_frame;
                            cmd.out_ld     = 1'b1;
                            cmd.out_status = !sts.in_frame;
                        end
                        OP_READ:
                        begin
                            cmd.host_rd = 1'b1;
                            rd_ok_next  = sts.in_frame;
                            state_next  = ST_RD_WAIT;
                        end
                        OP_BLUR:
                        begin
                            if (eff_r == '0)
                            begin
                                cmd.out_ld = 1'b1;
                            end
                            else
                            begin
                                vert_next  = 1'b0;
                                line_next  = '0;
                                state_next = ST_LINE_START;
                            end
                        end
                        default:
                        begin
                            cmd.out_ld = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                cmd.out_ld     = 1'b1;
                cmd.out_data   = rd_ok_reg;
                cmd.out_status = !rd_ok_reg;
                state_next     = ST_IDLE;
            end
            ST_LINE_START:
            begin
                cmd.acc_clr = 1'b1;
                fpos_next   = '0;
                kind_next   = KIND_PRIME;
                state_next  = ST_FETCH_ADDR;
            end
            ST_FETCH_ADDR:
            begin
                cmd.addr_ld = 1'b1;
                state_next  = ST_FETCH_RD;
            end
            ST_FETCH_RD:
            begin
                state_next = ST_FETCH_ACC;
            end
            ST_FETCH_ACC:
            begin
                unique case (kind_reg)
                    KIND_PRIME:
                    begin
                        cmd.acc_add = 1'b1;
                        if (fpos_reg == last)
                        begin
                            i_next     = '0;
                            state_next = ST_OUT_ADDR;
                        end
                        else
                        begin
                            fpos_next  = fpos_reg + 1'b1;
                            state_next = ST_FETCH_ADDR;
                        end
                    end
                    KIND_SUB:
                    begin
                        cmd.acc_sub = 1'b1;
                        if (add_ok)
                        begin
                            kind_next  = KIND_ADD;
                            fpos_next  = add_pos[DIM_W-1:0];
                            state_next = ST_FETCH_ADDR;
                        end
                        else
                        begin
                            state_next = ST_NEXT;
                        end
                    end
                    KIND_ADD:
                    begin
                        cmd.acc_add = 1'b1;
                        state_next  = ST_NEXT;
                    end
                    default:
                    begin
                        state_next = ST_NEXT;
                    end
                endcase
            end
            ST_OUT_ADDR:
            begin
                cmd.pos       = i_reg;
                cmd.addr_ld   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_DST_WR;
                end
            end
            ST_DST_WR:
            begin
                cmd.dst_wr = 1'b1;
                if (i_reg >= r_ext)
                begin
                    kind_next  = KIND_SUB;
                    fpos_next  = i_reg - r_ext;
                    state_next = ST_FETCH_ADDR;
                end
                else if (add_ok)
                begin
                    kind_next  = KIND_ADD;
                    fpos_next  = add_pos[DIM_W-1:0];
                    state_next = ST_FETCH_ADDR;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (i_reg == n_len - 1'b1)
                begin
                    if (line_reg == n_lines - 1'b1)
                    begin
                        if (vert_reg)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            vert_next  = 1'b1;
                            line_next  = '0;
                            state_next = ST_LINE_START;
                        end
                    end
                    else
                    begin
                        line_next  = line_reg + 1'b1;
                        state_next = ST_LINE_START;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_OUT_ADDR;
                end
            end
            ST_FINISH:
            begin
                cmd.out_ld = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: drop on transfer, raise on load
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_ld)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_PRIME;
            vert_reg      <= 1'b0;
            line_reg      <= '0;
            i_reg         <= '0;
            fpos_reg      <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            vert_reg      <= vert_next;
            line_reg      <= line_next;
            i_reg         <= i_next;
            fpos_reg      <= fpos_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new item is only taken with the sequencer at rest
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    // A division is never restarted while one runs
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider restarted while busy");

    // The destination is written only with a finished quotient
    a_dst_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dst_wr |-> !sts.div_busy && $past(state_reg) == ST_DIV_RUN)
        else $error("destination written before division finished");

    // A read transfer is answered on the following cycle
    a_read_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_READ) |=> cmd.out_ld)
        else $error("read result not loaded");

    // A result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.out_ld)
        else $error("pending result overwritten");

endmodule

// File: tb/tb_separable_box_blur_unit.sv
// Testbench for the separable box blur unit: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb_separable_box_blur_unit
    import sbb_pkg::*;
();

    typedef bit [2:0][15:0] pixel_t;   // [0] red, [1] green, [2] blue

    typedef struct {
        pixel_t px;
        bit     st;
    } blur_result_t;

    // Scoreboard: own copy of the frame and registers, queue of expected results
    class blur_scoreboard;
        pixel_t       frame[16384];
        pixel_t       row_pass[16384];
        int unsigned  radius;
        int unsigned  width;
        int unsigned  height;
        blur_result_t pending_q[$];
        int unsigned  errors;
        int unsigned  accepted;

        function new();
            radius   = 1;
            width    = 128;
            height   = 128;
            errors   = 0;
            accepted = 0;
        endfunction

        function void set_reg(logic [1:0] idx, bit [31:0] v);
            case (idx)
                REG_RADIUS: radius = v & 32'h7f;
                REG_WIDTH:  width  = v & 32'hff;
                REG_HEIGHT: height = v & 32'hff;
                default: ;
            endcase
        endfunction

        function int unsigned eff_w();
            if (width == 0) return 1;
            return (width > 128) ? 128 : width;
        endfunction

        function int unsigned eff_h();
            if (height == 0) return 1;
            return (height > 128) ? 128 : height;
        endfunction

        // Clipped box window, rows first into the row-pass store, then columns back
        function void blur_frame();
            int unsigned w, h, r, lo, hi, sum, cnt;
            w = eff_w();
            h = eff_h();
            r = (radius > 127) ? 127 : radius;
            if (r == 0) return;
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                    for (int c = 0; c < 3; c++) begin
                        lo  = (x > r) ? x - r : 0;
                        hi  = (x + r < w - 1) ? x + r : w - 1;
                        sum = 0;
                        for (int k = lo; k <= hi; k++)
                            sum += frame[y * w + k][c];
                        cnt = hi - lo + 1;
                        row_pass[y * w + x][c] = 16'((sum + cnt / 2) / cnt);
                    end
            for (int x = 0; x < w; x++)
                for (int y = 0; y < h; y++)
                    for (int c = 0; c < 3; c++) begin
                        lo  = (y > r) ? y - r : 0;
                        hi  = (y + r < h - 1) ? y + r : h - 1;
                        sum = 0;
                        for (int k = lo; k <= hi; k++)
                            sum += row_pass[k * w + x][c];
                        cnt = hi - lo + 1;
                        frame[y * w + x][c] = 16'((sum + cnt / 2) / cnt);
                    end
        endfunction

        function void note_item(logic [1:0] op, logic [13:0] idx, pixel_t p);
            blur_result_t res;
            bit in_frame;
            in_frame = idx < eff_w() * eff_h();
            res.px = '0;
            res.st = 1'b0;
            accepted++;
            case (op)
                OP_WRITE: if (in_frame) frame[idx] = p; else res.st = 1'b1;
                OP_BLUR:  blur_frame();
                OP_READ:  if (in_frame) res.px = frame[idx]; else res.st = 1'b1;
                default: ;
            endcase
            pending_q.push_back(res);
        endfunction

        function void check_result(pixel_t got_px, bit got_st);
            blur_result_t want;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result rgb=%h %h %h status=%0d",
                             got_px[0], got_px[1], got_px[2], got_st);
                return;
            end
            want = pending_q.pop_front();
            if (want.px !== got_px || want.st !== got_st) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected rgb=%h %h %h st=%0d, got rgb=%h %h %h st=%0d",
                             want.px[0], want.px[1], want.px[2], want.st,
                             got_px[0], got_px[1], got_px[2], got_st);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_ready;
    logic [1:0]  opcode;
    logic [13:0] pixel_index;
    logic [15:0] red_in, green_in, blue_in;
    logic        out_valid, out_ready;
    logic [15:0] red_out, green_out, blue_out;
    logic        status;

    blur_scoreboard sb;
    bit quiet;

    separable_box_blur_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
        .pixel_index(pixel_index), .red_in(red_in), .green_in(green_in),
        .blue_in(blue_in),
        .out_valid(out_valid), .out_ready(out_ready), .red_out(red_out),
        .green_out(green_out), .blue_out(blue_out), .status(status)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Stall the receiver at random, except in the quiet stretch
    always @(posedge clk)
    begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({blue_out, green_out, red_out}, status);
    end

    // Drive one item and hold it until the transfer
    task automatic send_item(logic [1:0] op, logic [13:0] idx, pixel_t p);
        if (!quiet)
            while ($urandom_range(99) < 12)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid    <= 1'b1;
        opcode      <= op;
        pixel_index <= idx;
        red_in      <= p[0];
        green_in    <= p[1];
        blue_in     <= p[2];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(op, idx, p);
        quiet = (sb.accepted >= 500 && sb.accepted < 700);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Setup then access cycle; the register takes the value at the access edge
    task automatic write_reg(logic [1:0] idx, bit [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p[0] = 16'($urandom);
        p[1] = 16'($urandom);
        p[2] = 16'($urandom);
        return p;
    endfunction

    // Random mix: writes, reads, out-of-frame indices, unused opcode, the odd blur
    task automatic random_items(int n, int blur_pct);
        int unsigned frame_px, pick;
        logic [13:0] idx;
        frame_px = sb.eff_w() * sb.eff_h();
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            idx  = 14'($urandom_range(frame_px - 1));
            if (pick < blur_pct)
                send_item(OP_BLUR, 14'($urandom), rand_pixel());
            else if (pick < 50)
                send_item(OP_WRITE, idx, rand_pixel());
            else if (pick < 85)
                send_item(OP_READ, idx, rand_pixel());
            else if (pick < 95 && frame_px < 16384)
                send_item($urandom_range(1) ? OP_READ : OP_WRITE,
                          14'($urandom_range(16383, frame_px)), rand_pixel());
            else
                send_item(OP_NONE, 14'($urandom), rand_pixel());
        end
    endtask

    int unsigned cfg_r[7] = '{0, 1, 127, 2, 3, 5, 1};
    int unsigned cfg_w[7] = '{5, 8, 6, 200, 1, 2, 9};
    int unsigned cfg_h[7] = '{4, 8, 5, 1, 0, 128, 3};

    initial
    begin
        pixel_t p;
        sb          = new();
        quiet       = 1'b0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        opcode      = OP_WRITE;
        pixel_index = '0;
        red_in      = '0;
        green_in    = '0;
        blue_in     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: sample extremes at the frame corners, unused opcode
        send_item(OP_WRITE, 14'd0, '0);
        send_item(OP_WRITE, 14'd16383, {3{16'hffff}});
        send_item(OP_WRITE, 14'd8191, {16'h5a5a, 16'ha5a5, 16'h0f0f});
        send_item(OP_READ, 14'd16383, '0);
        send_item(OP_READ, 14'd0, {3{16'hffff}});
        send_item(OP_READ, 14'd8191, '0);
        send_item(OP_NONE, 14'd16383, {3{16'hffff}});
        send_item(OP_NONE, 14'd0, '0);
        wait_idle();

        // Phases: one setting each, frame filled before any read or blur
        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(REG_RADIUS, cfg_r[ph]);
            write_reg(REG_WIDTH, cfg_w[ph]);
            write_reg(REG_HEIGHT, cfg_h[ph]);
            for (int k = 0; k < sb.eff_w() * sb.eff_h(); k++)
            begin
                p = rand_pixel();
                if (k == 0) p = '0;
                if (k == 1) p = {3{16'hffff}};
                send_item(OP_WRITE, 14'(k), p);
            end
            // Out-of-frame write and read, then a blur with read-back
            send_item(OP_WRITE, 14'd16383, rand_pixel());
            send_item(OP_READ, 14'(sb.eff_w() * sb.eff_h()), '0);
            send_item(OP_BLUR, '0, '0);
            send_item(OP_READ, 14'd0, '0);
            random_items(100, (sb.eff_w() * sb.eff_h() <= 64) ? 3 : 0);
            send_item(OP_BLUR, 14'($urandom), rand_pixel());
            send_item(OP_READ, 14'(sb.eff_w() * sb.eff_h() - 1), '0);
            wait_idle();
        end

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/sbb_pkg.sv
hdl/sbb_ram.sv
hdl/sbb_div.sv
hdl/sbb_dp.sv
hdl/sbb_ctrl.sv
hdl/separable_box_blur_unit.sv
tb/tb_separable_box_blur_unit.sv
